// ----- rtl/cpbw_pkg.sv -----
// Shared types and constants for the beam-weight depacketizer.
`default_nettype none

package cpbw_pkg;

   // Stream word geometry
   localparam int WORD_BITS  = 128;
   localparam int WORD_BYTES = WORD_BITS / 8;
   localparam int BYTE_IDX_W = $clog2(WORD_BYTES);

   // Register reset value
   localparam logic [4:0] WORDS_PER_BEAM_RESET = 5'd16;

   // Realignment phases, one-hot
   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_SECTION = 8'b0000_0010,
      PH_SPLIT   = 8'b0000_0100,
      PH_BEAM3   = 8'b0000_1000,
      PH_BEAM4   = 8'b0001_0000,
      PH_BEAM5   = 8'b0010_0000,
      PH_BEAM6   = 8'b0100_0000,
      PH_TAIL    = 8'b1000_0000
   } phase_type;

   // Section / beam configuration fields
   typedef struct packed {
      logic [11:0] element_mask;
      logic [3:0]  symbol_count;
      logic [7:0]  prb_count;
      logic [7:0]  start_prb;
      logic [3:0]  layer_index;
      logic [5:0]  start_symbol;
      logic [14:0] beam_number;
   } section_type;

   // Machine state carried from word to word
   typedef struct packed {
      phase_type              phase;
      logic                   expect_beam;
      logic [4:0]             word_count;
      logic [WORD_BITS-1:0]   carry;
      section_type            held;
   } state_type;

   // One result item
   typedef struct packed {
      logic                   beam_valid;
      logic                   coeff_valid;
      logic [WORD_BITS-1:0]   coeff;
      section_type            section;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_HEADER,
      expect_beam: 1'b0,
      word_count:  5'd0,
      carry:       {WORD_BITS{1'b0}},
      held:        '0
   };

endpackage

`default_nettype wire

// ----- rtl/cpbw_step.sv -----
// Combinational step: byte realignment, field capture and phase advance for one word.
`default_nettype none

module cpbw_step (
   input  wire cpbw_pkg::state_type              st,
   input  wire logic [cpbw_pkg::WORD_BITS-1:0]   word,
   input  wire logic                             last,
   input  wire logic [4:0]                       words_per_beam,
   output cpbw_pkg::state_type                   nxt,
   output cpbw_pkg::result_type                  res,
   output logic                                  res_present
);

   localparam int BW = cpbw_pkg::BYTE_IDX_W;
   localparam int NB = cpbw_pkg::WORD_BYTES;
   localparam int WB = cpbw_pkg::WORD_BITS;

   // byte k of a word
   function automatic logic [7:0] byte_of(input logic [WB-1:0] w, input logic [BW-1:0] k);
      byte_of = w[{k, 3'b000} +: 8];
   endfunction

   // bytes m and up from the carry, byte p below m from data byte m-1-p
   function automatic logic [WB-1:0] realign(input logic [WB-1:0] data,
                                             input logic [WB-1:0] carry,
                                             input logic [BW-1:0] m);
      logic [WB-1:0] r;
      logic [BW-1:0] src;
      r = '0;
      for (int p = 0; p < NB; p++) begin
         src = m - BW'(p) - BW'(1);
         if (BW'(p) >= m) r[p*8 +: 8] = carry[p*8 +: 8];
         else             r[p*8 +: 8] = byte_of(data, src);
      end
      return r;
   endfunction

   // carry byte q, q from s up, takes data byte s+15-q
   function automatic logic [WB-1:0] refill(input logic [WB-1:0] data,
                                            input logic [WB-1:0] carry,
                                            input logic [BW-1:0] s);
      logic [WB-1:0] r;
      logic [BW-1:0] src;
      r = carry;
      for (int q = 0; q < NB; q++) begin
         src = s + BW'(NB - 1) - BW'(q);
         if (BW'(q) >= s) r[q*8 +: 8] = byte_of(data, src);
      end
      return r;
   endfunction

   // byte offset used in each phase
   function automatic logic [BW-1:0] stride_of(input cpbw_pkg::phase_type ph);
      logic [BW-1:0] s;
      unique case (ph)
         cpbw_pkg::PH_SECTION: s = BW'(15);
         cpbw_pkg::PH_SPLIT:   s = BW'(15);
         cpbw_pkg::PH_BEAM3:   s = BW'(2);
         cpbw_pkg::PH_BEAM4:   s = BW'(5);
         cpbw_pkg::PH_BEAM5:   s = BW'(8);
         cpbw_pkg::PH_BEAM6:   s = BW'(11);
         default:              s = BW'(0);
      endcase
      return s;
   endfunction

   function automatic cpbw_pkg::phase_type phase_after(input cpbw_pkg::phase_type ph);
      cpbw_pkg::phase_type n;
      unique case (ph)
         cpbw_pkg::PH_HEADER:  n = cpbw_pkg::PH_SECTION;
         cpbw_pkg::PH_SECTION: n = cpbw_pkg::PH_SPLIT;
         cpbw_pkg::PH_SPLIT:   n = cpbw_pkg::PH_BEAM3;
         cpbw_pkg::PH_BEAM3:   n = cpbw_pkg::PH_BEAM4;
         cpbw_pkg::PH_BEAM4:   n = cpbw_pkg::PH_BEAM5;
         cpbw_pkg::PH_BEAM5:   n = cpbw_pkg::PH_BEAM6;
         cpbw_pkg::PH_BEAM6:   n = cpbw_pkg::PH_TAIL;
         default:              n = cpbw_pkg::PH_HEADER;
      endcase
      return n;
   endfunction

   // offset of the phase before, for the coefficient word still due on a beam word
   function automatic logic [BW-1:0] prev_stride(input cpbw_pkg::phase_type ph);
      logic [BW-1:0] s;
      unique case (ph)
         cpbw_pkg::PH_BEAM4: s = BW'(2);
         cpbw_pkg::PH_BEAM5: s = BW'(5);
         cpbw_pkg::PH_BEAM6: s = BW'(8);
         default:            s = BW'(0);
      endcase
      return s;
   endfunction

   logic [BW-1:0]        stride;
   logic [7:0]           id_hi;
   logic [7:0]           id_lo;
   logic                 counted;
   logic                 beam_hit;
   logic                 coeff_hit;
   logic [WB-1:0]        coeff;
   logic [4:0]           count_inc;
   cpbw_pkg::phase_type  jump_phase;

   assign stride = stride_of(st.phase);

   // per-phase capture and realignment
   always_comb begin
      nxt        = st;
      counted    = 1'b0;
      beam_hit   = 1'b0;
      coeff_hit  = 1'b0;
      coeff      = '0;
      jump_phase = st.phase;
      id_hi      = '0;
      id_lo      = '0;
      unique case (st.phase)
         cpbw_pkg::PH_HEADER: begin
            nxt.held.start_symbol = word[9*8 +: 6];
            nxt.held.layer_index  = word[2*8+4 +: 4];
            jump_phase            = cpbw_pkg::PH_SECTION;
         end
         cpbw_pkg::PH_SECTION: begin
            if (st.expect_beam) begin
               nxt.held.start_prb    = word[0*8 +: 8];
               nxt.held.prb_count    = word[1*8 +: 8];
               nxt.held.symbol_count = word[3*8 +: 4];
               nxt.held.element_mask = {word[2*8 +: 8], word[3*8+4 +: 4]};
               nxt.held.beam_number  = {word[13*8 +: 7], word[14*8 +: 8]};
               beam_hit              = 1'b1;
            end else begin
               coeff     = realign(word, st.carry, BW'(15));
               coeff_hit = 1'b1;
            end
            nxt.carry = refill(word, st.carry, BW'(15));
            counted   = 1'b1;
         end
         cpbw_pkg::PH_SPLIT: begin
            coeff      = realign(word, st.carry, BW'(15));
            coeff_hit  = 1'b1;
            jump_phase = cpbw_pkg::PH_BEAM3;
         end
         cpbw_pkg::PH_TAIL: begin
            coeff      = realign(word, st.carry, BW'(11));
            coeff_hit  = 1'b1;
            jump_phase = cpbw_pkg::PH_HEADER;
         end
         cpbw_pkg::PH_BEAM3, cpbw_pkg::PH_BEAM4, cpbw_pkg::PH_BEAM5,
         cpbw_pkg::PH_BEAM6: begin
            if (st.expect_beam) begin
               // finish the word of the previous beam first
               if (st.phase != cpbw_pkg::PH_BEAM3) begin
                  coeff     = realign(word, st.carry, prev_stride(st.phase));
                  coeff_hit = 1'b1;
               end
               if (last) begin
                  jump_phase = cpbw_pkg::PH_HEADER;
               end else begin
                  id_hi                = byte_of(word, stride - BW'(2));
                  id_lo                = byte_of(word, stride - BW'(1));
                  nxt.held.beam_number = {id_hi[6:0], id_lo};
                  beam_hit             = 1'b1;
                  nxt.carry            = refill(word, st.carry, stride);
                  counted              = 1'b1;
               end
            end else begin
               coeff     = realign(word, st.carry, stride);
               coeff_hit = 1'b1;
               nxt.carry = refill(word, st.carry, stride);
               counted   = 1'b1;
            end
         end
         default: begin
            jump_phase = cpbw_pkg::PH_HEADER;
         end
      endcase

      // word count and phase advance
      count_inc = st.word_count + 5'd1;
      if (counted) begin
         if (count_inc == words_per_beam) begin
            nxt.word_count  = 5'd0;
            nxt.expect_beam = 1'b1;
            nxt.phase       = phase_after(st.phase);
         end else begin
            nxt.word_count  = count_inc;
            nxt.expect_beam = 1'b0;
         end
      end else begin
         nxt.phase       = jump_phase;
         nxt.expect_beam = 1'b1;
      end
   end

   // result item, unused fields zero
   always_comb begin
      res             = '0;
      res.beam_valid  = beam_hit;
      res.coeff_valid = coeff_hit;
      if (coeff_hit) res.coeff = coeff;
      if (beam_hit)  res.section = nxt.held;
   end

   assign res_present = beam_hit | coeff_hit;

endmodule

`default_nettype wire

// ----- rtl/cplane_beam_weight_depacketizer_core.sv -----
// Top level of the control-plane beam-weight depacketizer: input, state and result registers.
`default_nettype none

// Takes one 128-bit control-plane word per clock while req_stall is low and returns at most
// one result per word: beam configuration (beam ID and section fields), a realigned 128-bit
// coefficient word, or both. Throughput is one word per cycle unless the result stalls.
// Each word is held in the input register, passes through the combinational step logic,
// whose state (phase, word count, byte carry, section fields) updates every cycle an item
// moves out of the input register, and is then captured in the result register. A stalled
// result holds the input register, so the block keeps one item in hand while a result waits.
// Header words and end-of-packet beam words in phase 3 produce no result. words_per_beam is
// written through csr_wr_en/csr_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce; 0 acts as 32.
module cplane_beam_weight_depacketizer_core (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // request channel
   input  wire  logic        req_valid,
   output logic              req_stall,
   input  wire  logic [63:0] req_word_low,
   input  wire  logic [63:0] req_word_high,
   input  wire  logic        req_end_of_packet,
   // response channel
   output logic              rsp_valid,
   input  wire  logic        rsp_stall,
   output logic              rsp_beam_valid,
   output logic              rsp_coeff_valid,
   output logic [63:0]       rsp_coeff_high,
   output logic [63:0]       rsp_coeff_low,
   output logic [14:0]       rsp_beam_number,
   output logic [5:0]        rsp_start_symbol,
   output logic [3:0]        rsp_layer_index,
   output logic [7:0]        rsp_start_prb,
   output logic [7:0]        rsp_prb_count,
   output logic [3:0]        rsp_symbol_count,
   output logic [11:0]       rsp_element_mask,
   // configuration
   input  wire  logic        csr_wr_en,
   input  wire  logic [4:0]  csr_wr_data
);

   logic                                s1_valid_ff, s1_valid_in;
   logic [cpbw_pkg::WORD_BITS-1:0]      s1_word_ff;
   logic                                s1_last_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   cpbw_pkg::result_type                rsp_data_ff;
   cpbw_pkg::state_type                 state_ff;
   cpbw_pkg::state_type                 state_in;
   cpbw_pkg::result_type                step_res;
   logic                                step_present;
   logic [4:0]                          wpb_ff;
   logic                                out_free;
   logic                                advance;
   logic                                req_xfer;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer)     s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = advance && step_present;
   end

   // step logic
   cpbw_step u_step (
      .st             (state_ff),
      .word           (s1_word_ff),
      .last           (s1_last_ff),
      .words_per_beam (wpb_ff),
      .nxt            (state_in),
      .res            (step_res),
      .res_present    (step_present)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= cpbw_pkg::STATE_RESET;
         wpb_ff       <= cpbw_pkg::WORDS_PER_BEAM_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance)   state_ff <= state_in;
         if (csr_wr_en) wpb_ff   <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_word_ff <= {req_word_high, req_word_low};
         s1_last_ff <= req_end_of_packet;
      end
      if (advance && out_free) rsp_data_ff <= step_res;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_beam_valid   = rsp_data_ff.beam_valid;
   assign rsp_coeff_valid  = rsp_data_ff.coeff_valid;
   assign rsp_coeff_high   = rsp_data_ff.coeff[127:64];
   assign rsp_coeff_low    = rsp_data_ff.coeff[63:0];
   assign rsp_beam_number  = rsp_data_ff.section.beam_number;
   assign rsp_start_symbol = rsp_data_ff.section.start_symbol;
   assign rsp_layer_index  = rsp_data_ff.section.layer_index;
   assign rsp_start_prb    = rsp_data_ff.section.start_prb;
   assign rsp_prb_count    = rsp_data_ff.section.prb_count;
   assign rsp_symbol_count = rsp_data_ff.section.symbol_count;
   assign rsp_element_mask = rsp_data_ff.section.element_mask;

   // checks
   a_rsp_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_beam_valid || rsp_coeff_valid))
      else $error("response transfer with neither beam nor coefficient");

   a_coeff_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_coeff_valid) |-> (rsp_coeff_high == 64'd0 && rsp_coeff_low == 64'd0))
      else $error("coefficient word not cleared without coefficient");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipe");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a word moving through");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the control-plane beam-weight depacketizer core.
module tb;

   // Directed table: each row is one stream word, optionally preceded by a register write
   typedef enum logic [1:0] {
      ROW_PREDICT,    // expectation comes from the predictor
      ROW_NO_RESULT,  // typed in: this word yields nothing
      ROW_RESULT      // typed in: the expectation held in the row
   } row_kind_type;

   typedef struct packed {
      logic                 do_cfg;
      logic [4:0]           cfg_value;
      logic [127:0]         word;
      logic                 last;
      row_kind_type         kind;
      cpbw_pkg::result_type typed;
   } stim_row_type;

   localparam logic [127:0] ALL_ONES = {128{1'b1}};
   localparam logic [127:0] ALL_ZERO = 128'h0;
   localparam logic [127:0] RAMP     = 128'h0F0E0D0C0B0A09080706050403020100;
   localparam logic [127:0] RAMP_INV = ~RAMP;
   localparam int           N_RANDOM_SEGMENTS = 5;
   localparam int           SEGMENT_ITEMS     = 110;
   localparam int           SQUEEZE_ITEM      = 300;
   localparam int           SQUEEZE_CYCLES    = 80;

   logic         clock;
   logic         reset             = 1'b1;
   logic         req_valid         = 1'b0;
   logic         req_stall;
   logic [63:0]  req_word_low      = 64'h0;
   logic [63:0]  req_word_high     = 64'h0;
   logic         req_end_of_packet = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall         = 1'b1;
   logic         rsp_beam_valid;
   logic         rsp_coeff_valid;
   logic [63:0]  rsp_coeff_high;
   logic [63:0]  rsp_coeff_low;
   logic [14:0]  rsp_beam_number;
   logic [5:0]   rsp_start_symbol;
   logic [3:0]   rsp_layer_index;
   logic [7:0]   rsp_start_prb;
   logic [7:0]   rsp_prb_count;
   logic [3:0]   rsp_symbol_count;
   logic [11:0]  rsp_element_mask;
   logic         csr_wr_en         = 1'b0;
   logic [4:0]   csr_wr_data       = 5'd0;

   // Predicted machine state
   cpbw_pkg::phase_type   bw_phase          = cpbw_pkg::PH_HEADER;
   logic                  bw_expect_beam    = 1'b0;
   logic [4:0]            bw_word_count     = 5'd0;
   logic [127:0]          bw_carry          = 128'h0;
   cpbw_pkg::section_type bw_held           = '0;
   logic [4:0]            bw_words_per_beam = cpbw_pkg::WORDS_PER_BEAM_RESET;

   cpbw_pkg::result_type pending_results[$];
   int                   mismatch_count    = 0;
   int                   rsp_count         = 0;
   bit                   calm              = 1'b0;
   bit                   squeeze_req       = 1'b0;
   bit                   squeeze_done      = 1'b0;

   cplane_beam_weight_depacketizer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_word_low      (req_word_low),
      .req_word_high     (req_word_high),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_beam_valid    (rsp_beam_valid),
      .rsp_coeff_valid   (rsp_coeff_valid),
      .rsp_coeff_high    (rsp_coeff_high),
      .rsp_coeff_low     (rsp_coeff_low),
      .rsp_beam_number   (rsp_beam_number),
      .rsp_start_symbol  (rsp_start_symbol),
      .rsp_layer_index   (rsp_layer_index),
      .rsp_start_prb     (rsp_start_prb),
      .rsp_prb_count     (rsp_prb_count),
      .rsp_symbol_count  (rsp_symbol_count),
      .rsp_element_mask  (rsp_element_mask),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pause_cycles();
      if (calm) return 0;
      return $urandom_range(0, 19);
   endfunction

   // Byte offset used by each phase when realigning and refilling the carry
   function automatic int byte_stride(cpbw_pkg::phase_type p);
      case (p)
         cpbw_pkg::PH_SECTION, cpbw_pkg::PH_SPLIT: return 15;
         cpbw_pkg::PH_BEAM3:                       return 2;
         cpbw_pkg::PH_BEAM4:                       return 5;
         cpbw_pkg::PH_BEAM5:                       return 8;
         cpbw_pkg::PH_BEAM6:                       return 11;
         default:                                  return 0;
      endcase
   endfunction

   // Bytes m..15 come from the carry, byte p below m from data byte m-1-p
   function automatic logic [127:0] realigned(logic [127:0] data, logic [127:0] carry, int m);
      logic [127:0] r;
      for (int p = 0; p < 16; p++)
         r[8*p +: 8] = (p >= m) ? carry[8*p +: 8] : data[8*(m-1-p) +: 8];
      return r;
   endfunction

   // Carry byte q, for q from s up, takes data byte s+15-q
   function automatic logic [127:0] refilled(logic [127:0] data, logic [127:0] carry, int s);
      logic [127:0] c;
      c = carry;
      for (int q = s; q < 16; q++)
         c[8*q +: 8] = data[8*(s+15-q) +: 8];
      return c;
   endfunction

   // Advance the predicted machine by one stream word
   task automatic depacketize_word(input logic [127:0] data, input bit last,
                                   output bit has_result, output cpbw_pkg::result_type res);
      cpbw_pkg::phase_type nxt;
      logic [127:0]        coeff;
      bit                  bv, cv, counted;
      int                  s;
      nxt     = bw_phase;
      coeff   = '0;
      bv      = 1'b0;
      cv      = 1'b0;
      counted = 1'b0;
      s       = byte_stride(bw_phase);
      case (bw_phase)
         cpbw_pkg::PH_HEADER: begin
            bw_held.start_symbol = data[72 +: 6];
            bw_held.layer_index  = data[20 +: 4];
            nxt = cpbw_pkg::PH_SECTION;
         end
         cpbw_pkg::PH_SECTION: begin
            if (bw_expect_beam) begin
               bw_held.start_prb    = data[7:0];
               bw_held.prb_count    = data[15:8];
               bw_held.symbol_count = data[27:24];
               bw_held.element_mask = {data[23:16], data[31:28]};
               bw_held.beam_number  = {data[110:104], data[119:112]};
               bv = 1'b1;
            end else begin
               coeff = realigned(data, bw_carry, s);
               cv = 1'b1;
            end
            bw_carry = refilled(data, bw_carry, s);
            counted = 1'b1;
         end
         cpbw_pkg::PH_SPLIT: begin
            coeff = realigned(data, bw_carry, s);
            cv = 1'b1;
            nxt = cpbw_pkg::PH_BEAM3;
         end
         cpbw_pkg::PH_TAIL: begin
            coeff = realigned(data, bw_carry, 11);
            cv = 1'b1;
            nxt = cpbw_pkg::PH_HEADER;
         end
         default: begin
            if (bw_expect_beam) begin
               // Beam word: phases past the first also flush the word still due
               if (bw_phase != cpbw_pkg::PH_BEAM3) begin
                  coeff = realigned(data, bw_carry,
                             byte_stride(cpbw_pkg::phase_type'({bw_phase[0], bw_phase[7:1]})));
                  cv = 1'b1;
               end
               if (last) begin
                  nxt = cpbw_pkg::PH_HEADER;
               end else begin
                  bw_held.beam_number = {data[8*(s-2) +: 7], data[8*(s-1) +: 8]};
                  bv = 1'b1;
                  bw_carry = refilled(data, bw_carry, s);
                  counted = 1'b1;
               end
            end else begin
               coeff = realigned(data, bw_carry, s);
               cv = 1'b1;
               bw_carry = refilled(data, bw_carry, s);
               counted = 1'b1;
            end
         end
      endcase

      if (counted) begin
         bw_word_count = bw_word_count + 5'd1;
         if (bw_word_count == bw_words_per_beam) begin
            bw_word_count  = 5'd0;
            bw_expect_beam = 1'b1;
            bw_phase       = cpbw_pkg::phase_type'({bw_phase[6:0], bw_phase[7]});
         end else begin
            bw_expect_beam = 1'b0;
         end
      end else begin
         bw_phase       = nxt;
         bw_expect_beam = 1'b1;
      end

      has_result      = bv || cv;
      res.beam_valid  = bv;
      res.coeff_valid = cv;
      res.coeff       = coeff;
      res.section     = bv ? bw_held : '0;
   endtask

   task automatic flag_mismatch(input string what, input logic [127:0] got,
                                input logic [127:0] want);
      mismatch_count++;
      $display("MISMATCH result %0d %s: got %h expected %h", rsp_count, what, got, want);
   endtask

   // Offer one word, hold it until the transfer, then book its expectation
   task automatic offer_word(input logic [127:0] word, input bit last,
                             input row_kind_type kind, input cpbw_pkg::result_type typed);
      int                   gap;
      bit                   has;
      cpbw_pkg::result_type res;
      gap = pause_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_word_low      <= word[63:0];
      req_word_high     <= word[127:64];
      req_end_of_packet <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      depacketize_word(word, last, has, res);
      if (kind == ROW_RESULT)
         pending_results.push_back(typed);
      else if (kind == ROW_PREDICT && has)
         pending_results.push_back(res);
   endtask

   // Register writes only with the block drained; resultless words may still be in flight
   task automatic write_words_per_beam(input logic [4:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bw_words_per_beam = value;
   endtask

   // Result side: random stall per transfer, one long hold-off on request
   initial begin
      int                   hold;
      cpbw_pkg::result_type want;
      while (reset) @(posedge clock);
      forever begin
         hold = pause_cycles();
         if (squeeze_req && !squeeze_done) begin
            hold = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_count++;
         if (pending_results.size() == 0) begin
            flag_mismatch("transfer with nothing pending", {rsp_coeff_high, rsp_coeff_low}, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_beam_valid !== want.beam_valid)
               flag_mismatch("beam_valid", rsp_beam_valid, want.beam_valid);
            if (rsp_coeff_valid !== want.coeff_valid)
               flag_mismatch("coeff_valid", rsp_coeff_valid, want.coeff_valid);
            if (rsp_coeff_high !== want.coeff[127:64])
               flag_mismatch("coeff_high", rsp_coeff_high, want.coeff[127:64]);
            if (rsp_coeff_low !== want.coeff[63:0])
               flag_mismatch("coeff_low", rsp_coeff_low, want.coeff[63:0]);
            if (rsp_beam_number !== want.section.beam_number)
               flag_mismatch("beam_number", rsp_beam_number, want.section.beam_number);
            if (rsp_start_symbol !== want.section.start_symbol)
               flag_mismatch("start_symbol", rsp_start_symbol, want.section.start_symbol);
            if (rsp_layer_index !== want.section.layer_index)
               flag_mismatch("layer_index", rsp_layer_index, want.section.layer_index);
            if (rsp_start_prb !== want.section.start_prb)
               flag_mismatch("start_prb", rsp_start_prb, want.section.start_prb);
            if (rsp_prb_count !== want.section.prb_count)
               flag_mismatch("prb_count", rsp_prb_count, want.section.prb_count);
            if (rsp_symbol_count !== want.section.symbol_count)
               flag_mismatch("symbol_count", rsp_symbol_count, want.section.symbol_count);
            if (rsp_element_mask !== want.section.element_mask)
               flag_mismatch("element_mask", rsp_element_mask, want.section.element_mask);
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type         rows[25];
      cpbw_pkg::result_type none;
      cpbw_pkg::result_type beam_ones;
      cpbw_pkg::result_type beam_zero;
      cpbw_pkg::result_type first_coeff;
      logic [4:0]           seg_wpb[N_RANDOM_SEGMENTS];
      logic [127:0]         word;
      bit                   last;
      int                   item_no;

      none        = '0;
      beam_ones   = '{beam_valid: 1'b1, coeff_valid: 1'b0, coeff: '0, section: '1};
      beam_zero   = '{beam_valid: 1'b1, coeff_valid: 1'b0, coeff: '0, section: '0};
      // carry byte 15 still holds the all-ones section word
      first_coeff = '{beam_valid: 1'b0, coeff_valid: 1'b1,
                      coeff: {8'hFF, 120'h0}, section: '0};

      // Reset-value packet, then two words per beam through every phase
      rows[0]  = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_NO_RESULT, none};
      rows[1]  = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_RESULT,    beam_ones};
      rows[2]  = '{1'b1, 5'd2, ALL_ZERO, 1'b0, ROW_RESULT,    first_coeff};
      rows[3]  = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[4]  = '{1'b0, 5'd0, RAMP_INV, 1'b0, ROW_PREDICT,   none};
      rows[5]  = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_PREDICT,   none};
      rows[6]  = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[7]  = '{1'b0, 5'd0, ALL_ZERO, 1'b0, ROW_PREDICT,   none};
      rows[8]  = '{1'b0, 5'd0, RAMP_INV, 1'b0, ROW_PREDICT,   none};
      rows[9]  = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[10] = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_PREDICT,   none};
      rows[11] = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[12] = '{1'b0, 5'd0, RAMP_INV, 1'b0, ROW_PREDICT,   none};
      // all-zero header; end of packet on the section word is ignored
      rows[13] = '{1'b0, 5'd0, ALL_ZERO, 1'b0, ROW_NO_RESULT, none};
      rows[14] = '{1'b0, 5'd0, ALL_ZERO, 1'b1, ROW_RESULT,    beam_zero};
      rows[15] = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[16] = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_PREDICT,   none};
      // end of packet on the first beam word drops back to the header silently
      rows[17] = '{1'b0, 5'd0, ALL_ZERO, 1'b1, ROW_NO_RESULT, none};
      rows[18] = '{1'b0, 5'd0, RAMP,     1'b0, ROW_NO_RESULT, none};
      rows[19] = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      rows[20] = '{1'b0, 5'd0, RAMP_INV, 1'b0, ROW_PREDICT,   none};
      rows[21] = '{1'b0, 5'd0, ALL_ZERO, 1'b0, ROW_PREDICT,   none};
      rows[22] = '{1'b0, 5'd0, ALL_ONES, 1'b0, ROW_PREDICT,   none};
      rows[23] = '{1'b0, 5'd0, RAMP,     1'b0, ROW_PREDICT,   none};
      // end of packet on a later beam word still flushes the pending coefficient
      rows[24] = '{1'b0, 5'd0, RAMP_INV, 1'b1, ROW_PREDICT,   none};

      seg_wpb = '{5'd1, 5'd31, 5'd7, 5'd2, cpbw_pkg::WORDS_PER_BEAM_RESET};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++) begin
         if (rows[i].do_cfg)
            write_words_per_beam(rows[i].cfg_value);
         offer_word(rows[i].word, rows[i].last, rows[i].kind, rows[i].typed);
      end

      // Random words; end of packet mostly where it matters, on beam words
      item_no = 0;
      for (int seg = 0; seg < N_RANDOM_SEGMENTS; seg++) begin
         write_words_per_beam(seg_wpb[seg]);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            calm = ((item_no / 40) % 3 == 2) ||
                   (item_no >= SQUEEZE_ITEM && item_no < SQUEEZE_ITEM + 40);
            if (item_no == SQUEEZE_ITEM)
               squeeze_req = 1'b1;
            word = {$urandom, $urandom, $urandom, $urandom};
            if (bw_expect_beam &&
                (bw_phase & (cpbw_pkg::PH_BEAM3 | cpbw_pkg::PH_BEAM4 |
                             cpbw_pkg::PH_BEAM5 | cpbw_pkg::PH_BEAM6)) != 0)
               last = ($urandom_range(0, 3) == 0);
            else
               last = ($urandom_range(0, 15) == 0);
            offer_word(word, last, ROW_PREDICT, none);
            item_no++;
         end
      end
      calm = 1'b0;

      // Drain, then allow for words still in the pipeline
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
